FILE: hdl/cpcg_pkg.sv
// ----------------------------------------------------------------------------
// cpcg_pkg
// Shared types and constants of the circle path curve generator.
// ----------------------------------------------------------------------------
package cpcg_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int PHASE_W     = FRAC_BITS + 2;
   localparam int STEP_W      = 18;
   localparam int COORD_W     = 18;
   localparam int MAG_W       = 17;
   localparam int RADIUS_W    = 16;
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 16;
   localparam int QUEUE_DEPTH = 2;

   // register map
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS     = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CURVE_MODE = 1'd1;

   // curve modes
   localparam logic MODE_BEZIER = 1'b0;
   localparam logic MODE_SPLINE = 1'b1;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd1280;
   // cos(pi/4) in Q0.16
   localparam logic [15:0]         COS45_Q16    = 16'd46341;

   typedef logic [PHASE_W-1:0]        phase_type;
   typedef logic signed [COORD_W-1:0] coord_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

FILE: hdl/cpcg_req_if.sv
// ----------------------------------------------------------------------------
// cpcg_req_if
// Request channel: phase step with valid/ready.
// ----------------------------------------------------------------------------
interface cpcg_req_if;
   import cpcg_pkg::*;

   logic              valid;
   logic              ready;
   logic [STEP_W-1:0] step;

   modport source (output valid, output step, input ready);
   modport sink   (input valid, input step, output ready);
endinterface

FILE: hdl/cpcg_rsp_if.sv
// ----------------------------------------------------------------------------
// cpcg_rsp_if
// Response channel: one point on the curve with valid/ready.
// ----------------------------------------------------------------------------
interface cpcg_rsp_if;
   import cpcg_pkg::*;

   logic               valid;
   logic               ready;
   logic signed [COORD_W-1:0] pos_x;
   logic signed [COORD_W-1:0] pos_y;
   logic signed [COORD_W-1:0] pos_z;
   logic [1:0]         segment;
   logic [PHASE_W-1:0] phase;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output segment, output phase, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   input segment, input phase, output ready);
endinterface

FILE: hdl/cpcg_csr_if.sv
// ----------------------------------------------------------------------------
// cpcg_csr_if
// Register write channel: index and data with valid/ready.
// ----------------------------------------------------------------------------
interface cpcg_csr_if;
   import cpcg_pkg::*;

   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hdl/cpcg_front.sv
// ----------------------------------------------------------------------------
// cpcg_front
// Phase accumulator: takes steps and queues the updated phase.
// ----------------------------------------------------------------------------
module cpcg_front (
   input  logic                        clock,
   input  logic                        reset,
   cpcg_req_if.sink                    req_bus,
   input  cpcg_pkg::queue_status_type  q_status,
   output logic                        push,
   output cpcg_pkg::phase_type         push_phase
);
   import cpcg_pkg::*;

   phase_type phase_acc_ff;
   phase_type phase_acc_in;
   logic      accept;

   assign req_bus.ready = !q_status.full;
   assign accept        = req_bus.valid && req_bus.ready;

   // wraps at 4.0 by width
   assign phase_acc_in = phase_acc_ff + req_bus.step[PHASE_W-1:0];
   assign push         = accept;
   assign push_phase   = phase_acc_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_acc_ff <= '0;
      end else if (accept) begin
         phase_acc_ff <= phase_acc_in;
      end
   end

endmodule

FILE: hdl/cpcg_queue.sv
// ----------------------------------------------------------------------------
// cpcg_queue
// Small fifo of phases between the accumulator and the evaluator.
// ----------------------------------------------------------------------------
module cpcg_queue (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  cpcg_pkg::phase_type         push_phase,
   input  logic                        pop,
   output cpcg_pkg::phase_type         pop_phase,
   output cpcg_pkg::queue_status_type  q_status
);
   import cpcg_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   phase_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;

   assign q_status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign q_status.empty = (count_ff == '0);
   assign pop_phase      = entry_ff[rd_ptr_ff];

   // depth is a power of two, so pointers wrap naturally
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_phase;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

FILE: hdl/cpcg_back.sv
// ----------------------------------------------------------------------------
// cpcg_back
// Curve evaluator: shared multiplier sequence and output register.
// ----------------------------------------------------------------------------
module cpcg_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic [cpcg_pkg::RADIUS_W-1:0]     radius,
   input  logic                              curve_mode,
   input  cpcg_pkg::queue_status_type        q_status,
   input  cpcg_pkg::phase_type               pop_phase,
   output logic                              pop,
   cpcg_rsp_if.source                        rsp_bus
);
   import cpcg_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_M1,
      ST_M2,
      ST_M3,
      ST_M4,
      ST_FIN
   } state_type;

   localparam int OPA_W  = 33;
   localparam int OPB_W  = 18;
   localparam int PROD_W = OPA_W + OPB_W;

   state_type          state_ff;
   phase_type          phase_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W-1:0]  prod_in;
   logic [OPA_W-1:0]   hold_ff;
   logic [15:0]        q_ff;
   logic [MAG_W-1:0]   mag0_ff;
   logic               rsp_valid_ff;
   coord_type          pos_x_ff, pos_y_ff, pos_z_ff;
   logic [1:0]         segment_ff;
   phase_type          phase_out_ff;

   logic [OPA_W-1:0]   op_a;
   logic [OPB_W-1:0]   op_b;
   logic [15:0]        u;
   logic [16:0]        w;
   logic [16:0]        lf;
   logic               lneg;
   logic [1:0]         seg;
   logic [PROD_W-1:0]  rnd_sum;
   logic [MAG_W-1:0]   mag1;
   logic [31:0]        q_sum;
   logic               out_free;
   logic               out_load;
   coord_type          x_in, y_in, z_in;

   function automatic coord_type to_coord(input logic [MAG_W-1:0] mag, input logic neg);
      coord_type m;
      m = coord_type'({1'b0, mag});
      return neg ? -m : m;
   endfunction

   assign u    = phase_ff[FRAC_BITS-1:0];
   assign seg  = phase_ff[PHASE_W-1:FRAC_BITS];
   assign w    = 17'h10000 - {1'b0, u};
   assign lneg = u[15] && (u[14:0] != '0);
   assign lf   = lneg ? ({u, 1'b0} - 17'h10000) : (17'h10000 - {u, 1'b0});

   // round half up of a Q.32 product
   assign rnd_sum = prod_ff + PROD_W'(64'h8000_0000);
   assign mag1    = rnd_sum[32 +: MAG_W];
   assign q_sum   = prod_ff[31:0] + 32'h4000;

   // multiplier operand selection per step
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (state_ff)
         ST_M1: begin
            op_a = OPA_W'(u);
            op_b = (curve_mode == MODE_BEZIER) ? OPB_W'(u) : OPB_W'(w);
         end
         ST_M2: begin
            if (curve_mode == MODE_BEZIER) begin
               op_a = OPA_W'(u);
               op_b = 18'h20000 - OPB_W'(u);
            end else begin
               op_a = OPA_W'(radius);
               op_b = OPB_W'(COS45_Q16);
            end
         end
         ST_M3: begin
            if (curve_mode == MODE_BEZIER) begin
               op_a = prod_ff[OPA_W-1:0];
               op_b = OPB_W'(radius);
            end else begin
               op_a = OPA_W'(prod_ff[31:0]);
               op_b = OPB_W'(lf);
            end
         end
         ST_M4: begin
            op_a = hold_ff;
            op_b = (curve_mode == MODE_BEZIER) ? OPB_W'(radius)
                                               : OPB_W'(17'h10000 + {1'b0, q_ff});
         end
         ST_IDLE, ST_FIN: begin
            op_a = '0;
            op_b = '0;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   // final point selection
   always_comb begin
      x_in = '0;
      y_in = '0;
      z_in = '0;
      if (curve_mode == MODE_BEZIER) begin
         case (seg)
            2'd0: begin y_in = to_coord(mag0_ff, 1'b0); z_in = to_coord(mag1, 1'b0); end
            2'd1: begin y_in = to_coord(mag1, 1'b0);    z_in = to_coord(mag0_ff, 1'b1); end
            2'd2: begin y_in = to_coord(mag0_ff, 1'b1); z_in = to_coord(mag1, 1'b1); end
            default: begin
               y_in = to_coord(mag1, 1'b1);
               z_in = to_coord(mag0_ff, 1'b0);
            end
         endcase
      end else begin
         case (seg)
            2'd0: begin x_in = to_coord(mag0_ff, lneg);  y_in = to_coord(mag1, 1'b0); end
            2'd1: begin x_in = to_coord(mag1, 1'b1);     y_in = to_coord(mag0_ff, lneg); end
            2'd2: begin x_in = to_coord(mag0_ff, !lneg); y_in = to_coord(mag1, 1'b1); end
            default: begin
               x_in = to_coord(mag1, 1'b0);
               y_in = to_coord(mag0_ff, !lneg);
            end
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign out_load = (state_ff == ST_FIN) && out_free;
   assign pop      = (state_ff == ST_IDLE) && !q_status.empty;

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.pos_x   = pos_x_ff;
   assign rsp_bus.pos_y   = pos_y_ff;
   assign rsp_bus.pos_z   = pos_z_ff;
   assign rsp_bus.segment = segment_ff;
   assign rsp_bus.phase   = phase_out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a new point replaces the one leaving in the same cycle
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_status.empty) begin
                  phase_ff <= pop_phase;
                  state_ff <= ST_M1;
               end
            end
            ST_M1: begin
               prod_ff  <= prod_in;
               state_ff <= ST_M2;
            end
            ST_M2: begin
               prod_ff <= prod_in;
               if (curve_mode == MODE_BEZIER) begin
                  hold_ff <= 33'h1_0000_0000 - prod_ff[OPA_W-1:0];
               end else begin
                  q_ff <= q_sum[30:15];
               end
               state_ff <= ST_M3;
            end
            ST_M3: begin
               prod_ff <= prod_in;
               if (curve_mode == MODE_SPLINE) begin
                  hold_ff <= OPA_W'(prod_ff[31:0]);
               end
               state_ff <= ST_M4;
            end
            ST_M4: begin
               prod_ff  <= prod_in;
               mag0_ff  <= mag1;
               state_ff <= ST_FIN;
            end
            ST_FIN: begin
               if (out_free) begin
                  pos_x_ff     <= x_in;
                  pos_y_ff     <= y_in;
                  pos_z_ff     <= z_in;
                  segment_ff   <= seg;
                  phase_out_ff <= phase_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

FILE: hdl/circle_path_curve_generator.sv
// path: a transferred step is queued, popped by the idle evaluator and taken through the
// evaluator's shared multiplier, which allows no overlap between points
//   (one pop step, four multiply steps, one output step)
// the 2-entry phase queue lets requests be taken while a point is computed or waits
// reset (synchronous, active high): phase 0, radius 5.0, quadratic mode, queue empty
// ----------------------------------------------------------------------------
// circle_path_curve_generator
// Steps a phase around four curve segments and returns a point on an
// approximate circle of programmable radius.
// ----------------------------------------------------------------------------
module circle_path_curve_generator (
   input  logic        clock,
   input  logic        reset,
   cpcg_req_if.sink    req_bus,
   cpcg_rsp_if.source  rsp_bus,
   cpcg_csr_if.sink    csr_bus
);
   import cpcg_pkg::*;

   // configuration registers
   logic [RADIUS_W-1:0] radius_ff;
   logic                curve_mode_ff;

   // front to queue
   logic             push;
   phase_type        push_phase;

   // queue to back
   logic             pop;
   phase_type        pop_phase;
   queue_status_type q_status;

   // register writes are always taken
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= RADIUS_RESET;
         curve_mode_ff <= MODE_BEZIER;
      end else if (csr_bus.valid) begin
         unique case (csr_bus.index)
            CSR_RADIUS:     radius_ff     <= csr_bus.data[RADIUS_W-1:0];
            CSR_CURVE_MODE: curve_mode_ff <= csr_bus.data[0];
            default: begin
            end
         endcase
      end
   end

   // phase accumulator, one step per request transfer
   cpcg_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .q_status   (q_status),
      .push       (push),
      .push_phase (push_phase)
   );

   // decouples the accumulator from the evaluator
   cpcg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_phase (push_phase),
      .pop        (pop),
      .pop_phase  (pop_phase),
      .q_status   (q_status)
   );

   // evaluator and response register
   cpcg_back u_back (
      .clock      (clock),
      .reset      (reset),
      .radius     (radius_ff),
      .curve_mode (curve_mode_ff),
      .q_status   (q_status),
      .pop_phase  (pop_phase),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

FILE: dv/tb_circle_path_curve_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_circle_path_curve_generator
// Self-checking bench for the circle path curve generator: steps are sent in
// bursts, each point is predicted from a local copy of phase, radius and mode,
// and every returned point is compared field by field in order of transfer.
// ----------------------------------------------------------------------------
module tb_circle_path_curve_generator;
   import cpcg_pkg::*;

   // one point as the block returns it
   typedef struct {
      coord_type  x;
      coord_type  y;
      coord_type  z;
      logic [1:0] seg;
      phase_type  ph;
   } curve_point_type;

   // receiver behaviors
   typedef enum int {
      STALL_NONE,
      STALL_RANDOM,
      STALL_LIGHT,
      STALL_RHYTHM
   } stall_style_type;

   localparam int        HOLD_CYCLES   = 400;
   localparam int        DRAIN_SETTLE  = 12;      // settle time after the last expected point
   localparam int        SWEEP_ITEMS   = 100;
   localparam longint    TIMEOUT_NS    = 5_000_000;
   localparam logic [63:0] ONE_Q       = 64'd1 << FRAC_BITS;

   logic clock;
   logic reset;

   cpcg_req_if req_if ();
   cpcg_rsp_if rsp_if ();
   cpcg_csr_if csr_if ();

   circle_path_curve_generator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   // local copy of the block's state and registers
   phase_type             model_phase;
   logic [RADIUS_W-1:0]   model_radius;
   logic                  model_mode;

   curve_point_type       expected_points [$];
   logic [STEP_W-1:0]     directed_steps [$];

   int              error_count    = 0;
   int              steps_sent     = 0;
   int              points_checked = 0;
   int              settings_count = 0;
   stall_style_type rsp_stall_style = STALL_NONE;
   logic            rsp_holding    = 1'b0;
   int              rsp_cycle      = 0;
   event            hold_start;

   // ------------------------------------------------------------------------
   // clock and run limit
   // ------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("timeout: %0d points still expected", expected_points.size());
      $display("FAIL");
      $finish;
   end

   // ------------------------------------------------------------------------
   // prediction
   // ------------------------------------------------------------------------
   // round(prod / 2^sh), half up
   function automatic logic [63:0] round_shift(input logic [63:0] prod, input int sh);
      return (prod + (64'd1 << (sh - 1))) >> sh;
   endfunction

   // magnitude and sign to a Q9.8 coordinate, wrapping to the port width
   function automatic coord_type to_coord(input logic [63:0] mag, input logic neg);
      logic [63:0] v;
      v = neg ? (64'd0 - mag) : mag;
      return coord_type'(v[COORD_W-1:0]);
   endfunction

   // advance the phase by one step and place the point on the curve
   function automatic curve_point_type advance_phase(input logic [STEP_W-1:0] step);
      curve_point_type p;
      logic [63:0]  u, w, full, a_mag, b_mag;
      logic [63:0]  radius_k, bump, h_mag, l_frac, l_mag;
      logic         l_neg;
      model_phase = phase_type'(model_phase + step);   // wraps at 4.0
      p.ph  = model_phase;
      p.seg = model_phase[PHASE_W-1:FRAC_BITS];
      u     = 64'(model_phase[FRAC_BITS-1:0]);
      w     = ONE_Q - u;
      p.x   = '0;
      p.y   = '0;
      p.z   = '0;
      if (model_mode == MODE_BEZIER) begin
         // quadratic segments in the y-z plane
         full  = 64'd1 << (2 * FRAC_BITS);
         a_mag = round_shift(64'(model_radius) * (full - w * w), 2 * FRAC_BITS);
         b_mag = round_shift(64'(model_radius) * (full - u * u), 2 * FRAC_BITS);
         case (p.seg)
            2'd0: begin p.y = to_coord(a_mag, 1'b0); p.z = to_coord(b_mag, 1'b0); end
            2'd1: begin p.y = to_coord(b_mag, 1'b0); p.z = to_coord(a_mag, 1'b1); end
            2'd2: begin p.y = to_coord(a_mag, 1'b1); p.z = to_coord(b_mag, 1'b1); end
            default: begin p.y = to_coord(b_mag, 1'b1); p.z = to_coord(a_mag, 1'b0); end
         endcase
      end else begin
         // spline segments in the x-y plane, scaled by r*cos(pi/4)
         radius_k = 64'(model_radius) * 64'(COS45_Q16);
         bump     = (2 * u * w + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
         h_mag    = round_shift(radius_k * (ONE_Q + bump), 16 + FRAC_BITS);
         l_neg    = (2 * u) > ONE_Q;
         l_frac   = l_neg ? (2 * u - ONE_Q) : (ONE_Q - 2 * u);
         l_mag    = round_shift(radius_k * l_frac, 16 + FRAC_BITS);
         // a zero magnitude comes out as zero whatever its sign
         case (p.seg)
            2'd0: begin p.x = to_coord(l_mag, l_neg);  p.y = to_coord(h_mag, 1'b0);   end
            2'd1: begin p.x = to_coord(h_mag, 1'b1);   p.y = to_coord(l_mag, l_neg);  end
            2'd2: begin p.x = to_coord(l_mag, !l_neg); p.y = to_coord(h_mag, 1'b1);   end
            default: begin p.x = to_coord(h_mag, 1'b0); p.y = to_coord(l_mag, !l_neg); end
         endcase
      end
      return p;
   endfunction

   // ------------------------------------------------------------------------
   // checking: every response transfer against the oldest expected point
   // ------------------------------------------------------------------------
   task automatic report_mismatch(input string field, input int got, input int want);
      error_count++;
      $display("mismatch at %0t: %s got %0d expected %0d", $realtime, field, got, want);
   endtask

   always @(posedge clock) begin : check_points
      curve_point_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_points.size() == 0) begin
            report_mismatch("unexpected point, phase", int'(rsp_if.phase), -1);
         end else begin
            want = expected_points.pop_front();
            points_checked++;
            if (rsp_if.pos_x !== want.x)
               report_mismatch("pos_x", int'(rsp_if.pos_x), int'(want.x));
            if (rsp_if.pos_y !== want.y)
               report_mismatch("pos_y", int'(rsp_if.pos_y), int'(want.y));
            if (rsp_if.pos_z !== want.z)
               report_mismatch("pos_z", int'(rsp_if.pos_z), int'(want.z));
            if (rsp_if.segment !== want.seg)
               report_mismatch("segment", int'(rsp_if.segment), int'(want.seg));
            if (rsp_if.phase !== want.ph)
               report_mismatch("phase", int'(rsp_if.phase), int'(want.ph));
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: stall pattern plus an occasional long hold-off
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : drive_rsp_ready
      logic take;
      rsp_cycle <= rsp_cycle + 1;
      case (rsp_stall_style)
         STALL_RANDOM: take = $urandom_range(0, 1);
         STALL_LIGHT:  take = ($urandom_range(0, 9) != 0);
         STALL_RHYTHM: take = ((rsp_cycle % 7) >= 3);   // ready held off at the start of each rhythm period
         default:      take = 1'b1;
      endcase
      rsp_if.ready <= take && !rsp_holding;
   end

   // long hold-off, counted here so the sender keeps pushing meanwhile
   initial begin
      forever begin
         @(hold_start);
         rsp_holding <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_holding <= 1'b0;
      end
   end

   // ------------------------------------------------------------------------
   // sender and register writes
   // ------------------------------------------------------------------------
   // offer one step and hold it until the transfer; valid stays high afterward
   task automatic send_step(input logic [STEP_W-1:0] step);
      req_if.valid <= 1'b1;
      req_if.step  <= step;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      expected_points.push_back(advance_phase(step));
      steps_sent++;
   endtask

   task automatic send_directed();
      foreach (directed_steps[i]) send_step(directed_steps[i]);
      req_if.valid <= 1'b0;
   endtask

   // mix of full-range steps, small ones and steps near segment edges
   function automatic logic [STEP_W-1:0] random_step();
      logic [STEP_W-1:0] s;
      case ($urandom_range(0, 9))
         5: s = STEP_W'($urandom_range(0, 255));
         6: s = STEP_W'(32'h10000 + $urandom_range(0, 64) - 32);
         7: s = STEP_W'(32'h3FFFF - $urandom_range(0, 64));
         8: s = STEP_W'({$urandom_range(0, 7), 15'h0});
         9: s = $urandom_range(0, 1) ? '1 : '0;
         default: s = STEP_W'($urandom());
      endcase
      return s;
   endfunction

   // random steps in bursts; gappy runs may drop valid between bursts
   task automatic run_steps(input int count, input bit gappy);
      int left;
      int burst;
      int gap;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 12);
         if (burst > left) burst = left;
         repeat (burst) send_step(random_step());
         left -= burst;
         gap = gappy ? $urandom_range(0, 8) : 0;
         if (left == 0) begin
            req_if.valid <= 1'b0;
         end else if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // all expected points in, then a few more cycles so the block is idle
   task automatic wait_drained();
      while (expected_points.size() != 0) @(posedge clock);
      repeat (DRAIN_SETTLE) @(posedge clock);
   endtask

   // register write; valid is left high so back-to-back writes stay clean
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= index;
      csr_if.data  <= data;
      do @(posedge clock); while (csr_if.ready !== 1'b1);
      if (index == CSR_RADIUS)
         model_radius = data;
      else if (index == CSR_CURVE_MODE)
         model_mode = data[0];
   endtask

   // new radius and mode, only once the block is idle; unused mode bits random
   task automatic apply_setting(input logic [RADIUS_W-1:0] radius, input logic mode);
      logic [CSR_DATA_W-1:0] mode_word;
      wait_drained();
      mode_word    = CSR_DATA_W'($urandom());
      mode_word[0] = mode;
      write_register(CSR_RADIUS, radius);
      write_register(CSR_CURVE_MODE, mode_word);
      csr_if.valid <= 1'b0;
      settings_count++;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------
   // reset radius and quadratic mode: wrap to exactly zero, edges, mid-segment
   task automatic test_reset_defaults();
      rsp_stall_style = STALL_NONE;
      directed_steps = '{18'h00000, 18'h3FFFF, 18'h00001, 18'h08000,
                         18'h08000, 18'h14000, 18'h10000, 18'h0C000};
      send_directed();
   endtask

   // extreme radii in both modes, including the zero-length spline term
   task automatic test_extreme_radius();
      apply_setting('1, MODE_SPLINE);
      directed_steps = '{18'h08000, 18'h08000, 18'h10000, 18'h10000,
                         18'h3FFFF, 18'h00001};
      send_directed();
      apply_setting('0, MODE_SPLINE);
      directed_steps = '{18'h12345, 18'h3FFFF};
      send_directed();
      apply_setting('1, MODE_BEZIER);
      directed_steps = '{18'h04000, 18'h10000, 18'h10000, 18'h10000};
      send_directed();
   endtask

   // random steps across a spread of settings and idling patterns
   task automatic test_random_sweep();
      logic [RADIUS_W-1:0] radii [9];
      logic                modes [9];
      radii = '{RADIUS_W'($urandom()), '1, '0, '1, RADIUS_W'($urandom()), '0,
                RADIUS_W'($urandom_range(1, 16)), RADIUS_RESET, RADIUS_W'($urandom())};
      modes = '{MODE_BEZIER, MODE_SPLINE, MODE_BEZIER, MODE_BEZIER, MODE_SPLINE,
                MODE_SPLINE, MODE_SPLINE, MODE_SPLINE, MODE_BEZIER};
      foreach (radii[i]) begin
         apply_setting(radii[i], modes[i]);
         rsp_stall_style = stall_style_type'(i % 4);
         run_steps(SWEEP_ITEMS, (i % 3) != 0);
      end
   endtask

   // receiver holds off while the sender keeps offering, so the block fills
   task automatic test_backpressure();
      apply_setting(RADIUS_W'($urandom()), MODE_SPLINE);
      rsp_stall_style = STALL_NONE;
      -> hold_start;
      run_steps(30, 1'b0);
      wait_drained();
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      req_if.valid = 1'b0;
      req_if.step  = '0;
      csr_if.valid = 1'b0;
      csr_if.index = CSR_RADIUS;
      csr_if.data  = '0;
      rsp_if.ready = 1'b0;
      model_phase  = '0;
      model_radius = RADIUS_RESET;
      model_mode   = MODE_BEZIER;

      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_extreme_radius();
      test_random_sweep();
      test_backpressure();

      wait_drained();
      $display("sent %0d steps and checked %0d points over %0d register settings",
               steps_sent, points_checked, settings_count);
      $display("both curve modes, radius extremes, phase wrap and a long receiver hold-off");
      if (error_count == 0) begin
         $display("PASS");
      end else begin
         $display("%0d mismatches", error_count);
         $display("FAIL");
      end
      $finish;
   end

endmodule
